// ===== src/hrbd_pkg.sv =====
// shared types, state codes and the per-bit destuffing step
package hrbd_pkg;

  localparam int DATA_W   = 12;
  localparam int COUNT_W  = 4;
  localparam int STATE_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // line state codes
  localparam logic [STATE_W-1:0] ST_ZERO      = 4'd0;
  localparam logic [STATE_W-1:0] ST_ZERO_ONE5 = 4'd5;
  localparam logic [STATE_W-1:0] ST_STUFF     = 4'd6;
  localparam logic [STATE_W-1:0] ST_ZERO_ONE6 = 4'd7;
  localparam logic [STATE_W-1:0] ST_FLAG_DONE = 4'd8;
  localparam logic [STATE_W-1:0] ST_ONE1      = 4'd9;
  localparam logic [STATE_W-1:0] ST_ONE5      = 4'd13;
  localparam logic [STATE_W-1:0] ST_ONE6      = 4'd14;
  localparam logic [STATE_W-1:0] ST_HUNT      = 4'd15;

  // register index of the mode register
  localparam logic REG_MODE = 1'b0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [STATE_W-1:0] st;
    logic [DATA_W-1:0]  bits;
    logic [COUNT_W-1:0] cnt;
    logic               sync;
    logic               hunt;
    logic               flag;
    logic               idle;
  } acc_t;

  typedef struct packed {
    logic               sync;
    logic               hunt;
    logic               flag;
    logic               idle;
  } status_t;

  // append an optional zero and then n ones to the gathered data
  function automatic acc_t put_bits(acc_t a, logic lead_zero, logic [2:0] n);
    acc_t        r;
    logic [4:0]  ones;
    logic [4:0]  pos;
    logic [31:0] m;
    logic [4:0]  sum;
    r    = a;
    ones = 5'((6'd1 << n) - 6'd1);
    pos  = {1'b0, a.cnt} + {4'd0, lead_zero};
    m    = 32'(ones) << pos;
    r.bits = a.bits | m[DATA_W-1:0];
    sum  = {1'b0, a.cnt} + {4'd0, lead_zero} + {2'd0, n};
    r.cnt = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    return r;
  endfunction

  // one line bit through the destuffer
  function automatic acc_t bit_step(acc_t a, logic b);
    acc_t r;
    r = a;
    case (a.st) inside
      [ST_ZERO:ST_ZERO_ONE5]: begin
        if (b) begin
          r.st = (a.st == ST_ZERO_ONE5) ? ST_ZERO_ONE6 : a.st + 4'd1;
        end else begin
          r    = put_bits(a, 1'b1, a.st[2:0]);
          r.st = (a.st == ST_ZERO_ONE5) ? ST_STUFF : ST_ZERO;
        end
      end
      ST_STUFF: begin
        r.st = b ? ST_ONE1 : ST_ZERO;
      end
      ST_ZERO_ONE6, ST_ONE6: begin
        if (b) begin
          if (a.st == ST_ZERO_ONE6) begin
            r = put_bits(a, 1'b1, 3'd0);
          end
          r.flag = 1'b0;
          r.hunt = 1'b1;
          r.st   = ST_HUNT;
        end else begin
          r.flag = 1'b1;
          r.hunt = 1'b0;
          r.st   = ST_FLAG_DONE;
        end
        r.sync = 1'b0;
        r.idle = 1'b0;
      end
      ST_FLAG_DONE: begin
        r.bits = '0;
        r.cnt  = '0;
        r.sync = 1'b1;
        r.flag = 1'b1;
        r.hunt = 1'b0;
        r.idle = 1'b0;
        r.st   = b ? ST_ONE1 : ST_ZERO;
      end
      [ST_ONE1:ST_ONE5]: begin
        if (b) begin
          r.st = a.st + 4'd1;
        end else begin
          r    = put_bits(a, 1'b0, 3'(a.st - ST_FLAG_DONE));
          r.st = (a.st == ST_ONE5) ? ST_STUFF : ST_ZERO;
        end
        r.idle = 1'b0;
      end
      default: begin
        r.sync = 1'b0;
        r.flag = 1'b0;
        r.hunt = 1'b1;
        r.idle = b;
        if (!b) begin
          r.st = ST_ZERO;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/hrbd_cfg.sv =====
// configuration register file with the mode bit
module hrbd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hrbd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hrbd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hrbd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic                       seven_bit_mode
);

  logic mode_r;
  logic mode_nxt;
  logic reg_idx;
  logic wr_en;

  assign reg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && reg_idx == hrbd_pkg::REG_MODE) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == hrbd_pkg::REG_MODE) begin
      cfg_prdata = {{(hrbd_pkg::CFG_DW-1){1'b0}}, mode_r};
    end
  end

  assign seven_bit_mode = mode_r;

endmodule

// ===== src/hrbd_unroll.sv =====
// one line byte through eight chained bit steps; seven-bit mode skips the last
module hrbd_unroll (
  input  logic [hrbd_pkg::STATE_W-1:0] state_in,
  input  logic [hrbd_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         seven_bit_mode,
  output logic [hrbd_pkg::STATE_W-1:0] state_out,
  output logic [hrbd_pkg::DATA_W-1:0]  data_bits,
  output logic [hrbd_pkg::COUNT_W-1:0] data_count,
  output hrbd_pkg::status_t            status
);

  hrbd_pkg::acc_t acc [hrbd_pkg::BYTE_W+1];

  always_comb begin
    acc[0]      = '0;
    acc[0].st   = state_in;
    for (int i = 0; i < hrbd_pkg::BYTE_W; i++) begin
      if (i < hrbd_pkg::BYTE_W - 1 || !seven_bit_mode) begin
        acc[i+1] = hrbd_pkg::bit_step(acc[i], rx_byte[3'(hrbd_pkg::BYTE_W - 1 - i)]);
      end else begin
        acc[i+1] = acc[i];
      end
    end
  end

  assign state_out   = acc[hrbd_pkg::BYTE_W].st;
  assign data_bits   = acc[hrbd_pkg::BYTE_W].bits;
  assign data_count  = acc[hrbd_pkg::BYTE_W].cnt;
  assign status.sync = acc[hrbd_pkg::BYTE_W].sync;
  assign status.hunt = acc[hrbd_pkg::BYTE_W].hunt;
  assign status.flag = acc[hrbd_pkg::BYTE_W].flag;
  assign status.idle = acc[hrbd_pkg::BYTE_W].idle;

endmodule

// ===== src/hdlc_rx_byte_destuffer_top.sv =====
// top level of the byte-wide receive destuffer
//
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata[7:0] rx_byte
// out_     out  out_tvalid/out_tready tdata data_bits, data_count; tuser status flags
// cfg_     in   apb psel/penable      mode register at address 0
//
// one byte per cycle while out_tready stays high; a request passes the input register
// and then the output register before out_tvalid rises
// the line state register closes the only loop, eight bit steps deep, the last skipped in seven-bit mode
// synchronous reset sets the line state to hunt and mode to eight bits
// a stalled result holds; one more request waits in the input register, then in_tready drops
module hdlc_rx_byte_destuffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [11:0] data_bits, [15:12] data_count
  output logic [3:0]  out_tuser,   // [0] sync_seen, [1] hunt_seen, [2] flag_seen, [3] idle_seen
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                         seven_bit_mode;
  logic                         s1_vld_r;
  logic                         s1_vld_nxt;
  logic [hrbd_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  logic [hrbd_pkg::DATA_W-1:0]  out_bits_r;
  logic [hrbd_pkg::COUNT_W-1:0] out_cnt_r;
  hrbd_pkg::status_t            out_stat_r;
  logic [hrbd_pkg::STATE_W-1:0] line_state_r;
  logic [hrbd_pkg::STATE_W-1:0] line_state_nxt;
  logic [hrbd_pkg::DATA_W-1:0]  calc_bits;
  logic [hrbd_pkg::COUNT_W-1:0] calc_cnt;
  hrbd_pkg::status_t            calc_stat;
  logic                         advance;
  logic                         in_acc;

  hrbd_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .seven_bit_mode (seven_bit_mode)
  );

  hrbd_unroll u_unroll (
    .state_in       (line_state_r),
    .rx_byte        (s1_byte_r),
    .seven_bit_mode (seven_bit_mode),
    .state_out      (line_state_nxt),
    .data_bits      (calc_bits),
    .data_count     (calc_cnt),
    .status         (calc_stat)
  );

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      line_state_r <= hrbd_pkg::ST_HUNT;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        line_state_r <= line_state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
    if (advance) begin
      out_bits_r <= calc_bits;
      out_cnt_r  <= calc_cnt;
      out_stat_r <= calc_stat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_cnt_r, out_bits_r};
  assign out_tuser  = {out_stat_r.idle, out_stat_r.flag, out_stat_r.hunt, out_stat_r.sync};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] <= 4'd12))
    else $error("data_count above twelve");

  a_bits_above_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[11:0] >> out_tdata[15:12]) == 12'd0))
    else $error("data bits set above data_count");

  a_hunt_flag_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("hunt and flag both set");

  a_sync_idle_imply : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((!out_tuser[0] || out_tuser[2]) && (!out_tuser[3] || out_tuser[1])))
    else $error("sync without flag or idle without hunt");

endmodule
